### sv/vrptw_route_cost_evaluator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the route cost evaluator checker.
// ---------------------------------------------------------------------------
`ifndef VRPTW_ROUTE_COST_EVALUATOR_ASSERT_SVH
`define VRPTW_ROUTE_COST_EVALUATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VRCE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VRCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### sv/vrce_pkg.sv
// ---------------------------------------------------------------------------
// vrce_pkg
// Types, widths and helpers shared by the route cost evaluator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package vrce_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned LEG_W  = 20;
  localparam int unsigned DEM_W  = 16;
  localparam int unsigned TW_W   = 20;
  localparam int unsigned CLK_W  = 22;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned LOAD_W = 24;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CAP_W  = 24;
  localparam int unsigned DL_W   = 22;
  localparam int unsigned PAD_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_VISIT     = 2'd0,
    OP_CLOSE     = 2'd1,
    OP_CLOSE_END = 2'd2
  } op_e;

  // Input beat payload, last member in the lowest bits.
  typedef struct packed {
    logic [TW_W-1:0]  service_time;
    logic [TW_W-1:0]  window_close;
    logic [TW_W-1:0]  window_open;
    logic [DEM_W-1:0] demand;
    logic [LEG_W-1:0] leg_distance;
  } in_data_t;

  localparam int unsigned IN_DATA_W = $bits(in_data_t);

  // Classified item as held in the queue.
  typedef struct packed {
    logic     close;
    logic     sol_end;
    in_data_t data;
  } item_t;

  // Figures of a closed route handed to the totals stage.
  typedef struct packed {
    logic [SUM_W-1:0]  route_distance;
    logic [SUM_W-1:0]  route_warp;
    logic [LOAD_W-1:0] route_load;
    logic [LOAD_W-1:0] route_excess;
    logic              nonempty;
    logic              sol_end;
  } close_t;

  // Result beat payload, last member in the lowest bits.
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic              feasible;
    logic [CNT_W-1:0]  used_routes;
    logic [SUM_W-1:0]  sum_excess;
    logic [SUM_W-1:0]  sum_warp;
    logic [SUM_W-1:0]  sum_distance;
    logic [LOAD_W-1:0] route_excess;
    logic [LOAD_W-1:0] route_load;
    logic [SUM_W-1:0]  route_warp;
    logic [SUM_W-1:0]  route_distance;
  } out_data_t;

  localparam int unsigned OUT_DATA_W = $bits(out_data_t);

  function automatic logic [SUM_W-1:0] sat_add32(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic logic [LOAD_W-1:0] sat_add24(input logic [LOAD_W-1:0] a,
                                                   input logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOAD_W] ? '1 : s[LOAD_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_add16(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/vrce_front.sv
// ---------------------------------------------------------------------------
// vrce_front
// Accepts input beats, decodes the op, drops unknown ops and queues items.
// ---------------------------------------------------------------------------
`default_nettype none

module vrce_front import vrce_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire logic [OP_W-1:0]      s_op_i,
  input  wire logic [IN_DATA_W-1:0] s_data_i,
  output logic                      item_valid_o,
  input  wire logic                 item_ready_i,
  output item_t                     item_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FifoDepth);

  item_t            mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             keep;
  item_t            item_new;
  logic             push;
  logic             pop;

  always_comb begin
    keep             = 1'b1;
    item_new.close   = 1'b0;
    item_new.sol_end = 1'b0;
    item_new.data    = in_data_t'(s_data_i);
    unique case (op_e'(s_op_i))
      OP_VISIT: begin
        item_new.close = 1'b0;
      end
      OP_CLOSE: begin
        item_new.close = 1'b1;
      end
      OP_CLOSE_END: begin
        item_new.close   = 1'b1;
        item_new.sol_end = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_ready_o    = (count_q != CntFull);
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = s_valid_i && s_ready_o && keep;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

### sv/vrce_route.sv
// ---------------------------------------------------------------------------
// vrce_route
// Per-route state: arrival time, time windows, load and the route close.
// ---------------------------------------------------------------------------
`default_nettype none

module vrce_route import vrce_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  output logic                   item_ready_o,
  input  wire item_t             item_i,
  input  wire logic [CAP_W-1:0]  capacity_i,
  input  wire logic [DL_W-1:0]   deadline_i,
  output logic                   close_valid_o,
  input  wire logic              close_ready_i,
  output close_t                 close_o
);

  logic [CLK_W-1:0]  clock_now_q, clock_now_d;
  logic [TW_W-1:0]   last_svc_q, last_svc_d;
  logic              has_visits_q, has_visits_d;
  logic [SUM_W-1:0]  rdist_q, rdist_d;
  logic [SUM_W-1:0]  rwarp_q, rwarp_d;
  logic [LOAD_W-1:0] rload_q, rload_d;
  logic              close_valid_q, close_valid_d;
  close_t            close_q, close_d;

  logic              fire;
  logic [CLK_W-1:0]  leg_ext;
  logic [CLK_W-1:0]  wo_ext;
  logic [CLK_W-1:0]  wc_ext;
  logic [CLK_W-1:0]  travel;
  logic [CLK_W-1:0]  arrive;
  logic [CLK_W-1:0]  raised;
  logic              late;
  logic [SUM_W-1:0]  dist_new;
  logic [SUM_W-1:0]  visit_warp;
  logic              dl_late;
  logic [SUM_W-1:0]  close_warp;
  logic [LOAD_W-1:0] excess;

  assign item_ready_o  = !close_valid_q || close_ready_i;
  assign fire          = item_valid_i && item_ready_o;
  assign close_valid_o = close_valid_q;
  assign close_o       = close_q;

  // One adder covers both the next arrival and the return to the depot.
  always_comb begin
    leg_ext  = CLK_W'(item_i.data.leg_distance);
    wo_ext   = CLK_W'(item_i.data.window_open);
    wc_ext   = CLK_W'(item_i.data.window_close);
    travel   = clock_now_q + CLK_W'(last_svc_q) + leg_ext;
    arrive   = has_visits_q ? travel : leg_ext;
    raised   = (arrive < wo_ext) ? wo_ext : arrive;
    late     = (raised > wc_ext);
    dist_new = sat_add32(rdist_q, SUM_W'(item_i.data.leg_distance));
    visit_warp = late ? sat_add32(rwarp_q, SUM_W'(raised - wc_ext)) : rwarp_q;
    dl_late    = (travel > CLK_W'(deadline_i));
    close_warp = dl_late ? sat_add32(rwarp_q, SUM_W'(travel - CLK_W'(deadline_i)))
                         : rwarp_q;
    excess     = (rload_q > capacity_i) ? (rload_q - capacity_i) : '0;
  end

  always_comb begin
    clock_now_d   = clock_now_q;
    last_svc_d    = last_svc_q;
    has_visits_d  = has_visits_q;
    rdist_d       = rdist_q;
    rwarp_d       = rwarp_q;
    rload_d       = rload_q;
    close_valid_d = close_ready_i ? 1'b0 : close_valid_q;
    close_d       = close_q;
    if (fire) begin
      if (item_i.close) begin
        close_valid_d          = 1'b1;
        close_d.nonempty       = has_visits_q;
        close_d.sol_end        = item_i.sol_end;
        close_d.route_distance = has_visits_q ? dist_new : '0;
        close_d.route_warp     = has_visits_q ? close_warp : '0;
        close_d.route_load     = rload_q;
        close_d.route_excess   = has_visits_q ? excess : '0;
        clock_now_d  = '0;
        last_svc_d   = '0;
        has_visits_d = 1'b0;
        rdist_d      = '0;
        rwarp_d      = '0;
        rload_d      = '0;
      end else begin
        clock_now_d  = late ? wc_ext : raised;
        last_svc_d   = item_i.data.service_time;
        has_visits_d = 1'b1;
        rdist_d      = dist_new;
        rwarp_d      = visit_warp;
        rload_d      = sat_add24(rload_q, LOAD_W'(item_i.data.demand));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_now_q   <= '0;
      last_svc_q    <= '0;
      has_visits_q  <= 1'b0;
      rdist_q       <= '0;
      rwarp_q       <= '0;
      rload_q       <= '0;
      close_valid_q <= 1'b0;
    end else begin
      clock_now_q   <= clock_now_d;
      last_svc_q    <= last_svc_d;
      has_visits_q  <= has_visits_d;
      rdist_q       <= rdist_d;
      rwarp_q       <= rwarp_d;
      rload_q       <= rload_d;
      close_valid_q <= close_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    close_q <= close_d;
  end

endmodule

`default_nettype wire

### sv/vrce_totals.sv
// ---------------------------------------------------------------------------
// vrce_totals
// Running solution totals and the registered result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module vrce_totals import vrce_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  close_valid_i,
  output logic       close_ready_o,
  input  wire close_t close_i,
  output logic       m_valid_o,
  input  wire logic  m_ready_i,
  output out_data_t  m_data_o,
  output logic       m_done_o
);

  logic [SUM_W-1:0] tot_dist_q, tot_dist_d;
  logic [SUM_W-1:0] tot_warp_q, tot_warp_d;
  logic [SUM_W-1:0] tot_exc_q, tot_exc_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_data_t        out_q, out_d;
  logic             done_q, done_d;

  logic             load;
  logic [SUM_W-1:0] dist_sum;
  logic [SUM_W-1:0] warp_sum;
  logic [SUM_W-1:0] exc_sum;
  logic [CNT_W-1:0] cnt_sum;

  assign close_ready_o = !out_valid_q || m_ready_i;
  assign load          = close_valid_i && close_ready_o;
  assign m_valid_o     = out_valid_q;
  assign m_data_o      = out_q;
  assign m_done_o      = done_q;

  // An empty close carries zero figures, so adding it leaves the totals as they are.
  always_comb begin
    dist_sum = sat_add32(tot_dist_q, close_i.route_distance);
    warp_sum = sat_add32(tot_warp_q, close_i.route_warp);
    exc_sum  = sat_add32(tot_exc_q, SUM_W'(close_i.route_excess));
    cnt_sum  = sat_add16(count_q, CNT_W'(close_i.nonempty));
  end

  always_comb begin
    tot_dist_d  = tot_dist_q;
    tot_warp_d  = tot_warp_q;
    tot_exc_d   = tot_exc_q;
    count_d     = count_q;
    out_valid_d = m_ready_i ? 1'b0 : out_valid_q;
    out_d       = out_q;
    done_d      = done_q;
    if (load) begin
      out_valid_d          = 1'b1;
      out_d.pad            = '0;
      out_d.route_distance = close_i.route_distance;
      out_d.route_warp     = close_i.route_warp;
      out_d.route_load     = close_i.route_load;
      out_d.route_excess   = close_i.route_excess;
      out_d.sum_distance   = dist_sum;
      out_d.sum_warp       = warp_sum;
      out_d.sum_excess     = exc_sum;
      out_d.used_routes    = cnt_sum;
      out_d.feasible       = (exc_sum == '0) && (warp_sum == '0);
      done_d               = close_i.sol_end;
      tot_dist_d = close_i.sol_end ? '0 : dist_sum;
      tot_warp_d = close_i.sol_end ? '0 : warp_sum;
      tot_exc_d  = close_i.sol_end ? '0 : exc_sum;
      count_d    = close_i.sol_end ? '0 : cnt_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_dist_q  <= '0;
      tot_warp_q  <= '0;
      tot_exc_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tot_dist_q  <= tot_dist_d;
      tot_warp_q  <= tot_warp_d;
      tot_exc_q   <= tot_exc_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    done_q <= done_d;
  end

endmodule

`default_nettype wire

### sv/vrptw_route_cost_evaluator.sv
// ---------------------------------------------------------------------------
// vrptw_route_cost_evaluator
// Time-window route evaluation: one client visit per beat, one result per close.
// ---------------------------------------------------------------------------
// The block takes one beat per clock cycle and sustains that rate for any mix
// of visits and closes while the result stream takes its beats; the per-visit
// arrival time update is a single add, clamp and compare step in the route
// stage, and that loop sets the rate. A close beat passes the queue, the route
// stage register and the totals register in turn before its result beat is
// valid. A stalled result stream holds a pending close, which in turn holds the
// queue. Beats with the unused op code are accepted and dropped. The user must
// write registers over the APB port only while no beat is in flight; the block
// itself does not enforce this. Reads return the current register values.
`default_nettype none

module vrptw_route_cost_evaluator import vrce_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // APB configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // Input stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: leg_distance, demand, window_open, window_close, service_time
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: op
  input  wire logic [OP_W-1:0]       s_axis_tuser_i,
  // Result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // tdata: route_distance, route_warp, route_load, route_excess, sum_distance,
  //        sum_warp, sum_excess, used_routes, feasible, zero padding
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // tlast: solution_done
  output logic                       m_axis_tlast_o
);

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_DEADLINE = 1'b1;

  logic [CAP_W-1:0] capacity_q, capacity_d;
  logic [DL_W-1:0]  deadline_q, deadline_d;
  logic             cfg_write;
  logic             reg_sel;

  logic             item_valid;
  logic             item_ready;
  item_t            item;
  logic             close_valid;
  logic             close_ready;
  close_t           close_info;
  out_data_t        out_data;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    capacity_d = capacity_q;
    deadline_d = deadline_q;
    if (cfg_write) begin
      unique case (reg_sel)
        REG_CAPACITY: capacity_d = pwdata[CAP_W-1:0];
        REG_DEADLINE: deadline_d = pwdata[DL_W-1:0];
        default:      capacity_d = capacity_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CAPACITY: prdata = 32'(capacity_q);
      REG_DEADLINE: prdata = 32'(deadline_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
      deadline_q <= '1;
    end else begin
      capacity_q <= capacity_d;
      deadline_q <= deadline_d;
    end
  end

  vrce_front #(
    .FifoDepth(FifoDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_op_i       (s_axis_tuser_i),
    .s_data_i     (s_axis_tdata_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  vrce_route u_route (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .capacity_i    (capacity_q),
    .deadline_i    (deadline_q),
    .close_valid_o (close_valid),
    .close_ready_i (close_ready),
    .close_o       (close_info)
  );

  vrce_totals u_totals (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .close_valid_i (close_valid),
    .close_ready_o (close_ready),
    .close_i       (close_info),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_data_o      (out_data),
    .m_done_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_data;

endmodule

`default_nettype wire

### sv/vrce_checker.sv
// ---------------------------------------------------------------------------
// vrce_checker
// Port-level checks on the result stream of the route cost evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

`include "vrptw_route_cost_evaluator_assert.svh"

module vrce_checker import vrce_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  m_axis_tvalid_i,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input wire logic                  m_axis_tlast_i
);

  out_data_t res;

  assign res = out_data_t'(m_axis_tdata_i);

  // The feasibility flag must agree with the totals it is derived from.
  `VRCE_ASSERT_IMPL(a_feasible_flag, clk_i, rst_ni, m_axis_tvalid_i, res.feasible == ((res.sum_warp == '0) && (res.sum_excess == '0)))

  // Excess is the part of the load above capacity, never more than the load.
  `VRCE_ASSERT_IMPL(a_excess_in_load, clk_i, rst_ni, m_axis_tvalid_i, res.route_excess <= res.route_load)

  // Totals already include the route just closed, and saturation keeps that order.
  `VRCE_ASSERT_IMPL(a_totals_cover_route, clk_i, rst_ni, m_axis_tvalid_i, (res.sum_distance >= res.route_distance) && (res.sum_warp >= res.route_warp) && (res.sum_excess >= SUM_W'(res.route_excess)))

  // A stalled result beat holds.
  `VRCE_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))

endmodule

bind vrptw_route_cost_evaluator vrce_checker u_vrce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire
